[src/sdcr_pkg.sv]
// ----------------------------------------------------------------------------
// sdcr_pkg
// Shared types, codes and helpers of the strip detector centroid/RMS core.
// ----------------------------------------------------------------------------
package sdcr_pkg;

	localparam int NUM_STRIPS_DEF = 16;
	localparam int Q_MAX          = 4095;
	localparam int SUM_MAX        = 1048575;

	localparam logic [15:0] GATE_HIGH_RST = 16'd8192;

	// configuration register indexes
	localparam logic [2:0] CFG_IMPLANT_LO = 3'd0;
	localparam logic [2:0] CFG_IMPLANT_HI = 3'd1;
	localparam logic [2:0] CFG_DECAY_LO   = 3'd2;
	localparam logic [2:0] CFG_DECAY_HI   = 3'd3;
	localparam logic [2:0] CFG_PEAK_POS   = 3'd4;
	localparam logic [2:0] CFG_DECAY_EN   = 3'd5;

	// event kinds
	localparam logic [1:0] KIND_IMPLANT = 2'd0;
	localparam logic [1:0] KIND_DECAY   = 2'd1;

	typedef enum logic [2:0] {
		S_COLLECT,
		S_P1,
		S_CALC,
		S_WAIT,
		S_P2,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		ST_CEN,
		ST_CENG,
		ST_SPR_DIV,
		ST_SPR_SQRT,
		ST_SPRG_DIV,
		ST_SPRG_SQRT
	} step_t;

	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} unit_op_t;

	typedef struct packed {
		logic     start;
		unit_op_t op;
	} unit_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	function automatic logic [11:0] sat_q12(input logic [31:0] v);
		return (v > 32'(Q_MAX)) ? 12'(Q_MAX) : v[11:0];
	endfunction

	function automatic logic [19:0] sat_sum(input logic [31:0] v);
		return (v > 32'(SUM_MAX)) ? 20'(SUM_MAX) : v[19:0];
	endfunction

endpackage

[src/sdcr_if.sv]
// ----------------------------------------------------------------------------
// sdcr_if
// Handshake channels: strip items in, event results out.
// ----------------------------------------------------------------------------
interface sdcr_strip_if;
	logic        valid;
	logic        ready;
	logic [15:0] strip_energy;
	logic        strip_fired;
	logic [1:0]  event_kind;
	logic        last_strip;

	modport source (output valid, strip_energy, strip_fired, event_kind, last_strip,
		input ready);
	modport sink (input valid, strip_energy, strip_fired, event_kind, last_strip,
		output ready);
endinterface

interface sdcr_result_if;
	logic        valid;
	logic        ready;
	logic [4:0]  fired_count;
	logic [4:0]  gated_count;
	logic [15:0] top_energy_first;
	logic [15:0] top_energy_second;
	logic [15:0] top_energy_third;
	logic [19:0] energy_sum;
	logic [11:0] centroid;
	logic        centroid_valid;
	logic [11:0] gated_centroid;
	logic        gated_centroid_valid;
	logic [11:0] spread;
	logic [11:0] gated_spread;

	modport source (output valid, fired_count, gated_count, top_energy_first,
		top_energy_second, top_energy_third, energy_sum, centroid, centroid_valid,
		gated_centroid, gated_centroid_valid, spread, gated_spread, input ready);
	modport sink (input valid, fired_count, gated_count, top_energy_first,
		top_energy_second, top_energy_third, energy_sum, centroid, centroid_valid,
		gated_centroid, gated_centroid_valid, spread, gated_spread, output ready);
endinterface

[src/sdcr_unit.sv]
// ----------------------------------------------------------------------------
// sdcr_unit
// Shared compare/subtract unit: restoring division or integer square root,
// one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module sdcr_unit #(
	parameter int NW   = 64,
	parameter int QW   = 24,
	parameter int CNTW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sdcr_pkg::unit_cmd_t cmd,
	input  logic [NW-1:0]       num,
	input  logic [NW-1:0]       opd,
	input  logic [CNTW-1:0]     iters,
	output sdcr_pkg::unit_sts_t sts,
	output logic [QW-1:0]       quo
);
	import sdcr_pkg::*;

	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   opd_q;
	logic [QW-1:0]   q_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	unit_op_t        op_q;

	logic [NW-1:0] trial;
	logic [NW-1:0] diff;
	logic          ge;

	always_comb begin
		trial = (op_q == OP_SQRT) ? (NW'(q_q) | opd_q) : opd_q;
		ge    = rem_q >= trial;
		diff  = rem_q - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_DIV;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= iters;
			op_q   <= cmd.op;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= num;
			opd_q <= opd;
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
			end
			if (op_q == OP_DIV) begin
				q_q   <= {q_q[QW-2:0], ge};
				opd_q <= opd_q >> 1;
			end else begin
				q_q   <= ge ? ((q_q >> 1) | opd_q[QW-1:0]) : (q_q >> 1);
				opd_q <= opd_q >> 2;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = q_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q) else $error("unit started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("unit done held");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("unit done without work");
`endif

endmodule

[src/strip_detector_centroid_rms_core.sv]
// ----------------------------------------------------------------------------
// strip_detector_centroid_rms_core
// Energy-weighted centroid and RMS width of one segmented-detector event.
// ----------------------------------------------------------------------------
// Strip items arrive on the strips channel, strip 0 first; the item with
// last_strip set closes the event and its event_kind selects the gate.
// One result item per event leaves on the results channel.
// Strips are taken one per cycle while collecting. After the last strip of a
// defined event the block is not ready: one pass over the strip memory, two
// centroid divisions, then for each width a weighting pass, a division and a
// square root. The event time is set by the single shared divide/root unit
// and the one-port strip memory.
// Undefined events skip these steps and go straight to S_DONE, which loads
// their all-zero result.
// The result sits in an output register; the next event's strips are taken
// while it waits, and only the loading of that next event's result waits for
// the receiver. Reset clears the control state and sets the configuration
// registers to their reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module strip_detector_centroid_rms_core #(
	parameter int NUM_STRIPS = sdcr_pkg::NUM_STRIPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	sdcr_strip_if.sink    strips,
	sdcr_result_if.source results
);
	import sdcr_pkg::*;

	localparam int IW  = $clog2(NUM_STRIPS);
	localparam int CW  = $clog2(NUM_STRIPS + 1);
	localparam int DW  = 16 + CW;
	localparam int PW  = 16 + IW + CW;
	localparam int CQ  = IW + 8;
	localparam int QS  = 2 * CQ;
	localparam int SW  = QS + 16 + CW;
	localparam int UCW = $clog2(QS + 1);

	// configuration
	logic [15:0] imp_lo_q, imp_hi_q, dec_lo_q, dec_hi_q;
	logic        peak_pos_q, dec_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imp_lo_q   <= '0;
			imp_hi_q   <= GATE_HIGH_RST;
			dec_lo_q   <= '0;
			dec_hi_q   <= GATE_HIGH_RST;
			peak_pos_q <= 1'b0;
			dec_en_q   <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_IMPLANT_LO: imp_lo_q   <= cfg_data;
				CFG_IMPLANT_HI: imp_hi_q   <= cfg_data;
				CFG_DECAY_LO:   dec_lo_q   <= cfg_data;
				CFG_DECAY_HI:   dec_hi_q   <= cfg_data;
				CFG_PEAK_POS:   peak_pos_q <= cfg_data[0];
				CFG_DECAY_EN:   dec_en_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// control
	state_t state_q, state_d;
	step_t  step_q, step_d;
	logic   sel_g_q;
	logic   zero_q;
	logic   implant_q;
	logic [CW-1:0] cnt_q, n_q, rd_idx_q;
	logic   v_s1, v_s2;
	logic   res_valid_q;

	logic strip_acc, defined, issue, pass_end, load, unit_start, enter_p2;
	logic [CW-1:0] cnt_inc;

	unit_cmd_t      ucmd;
	unit_sts_t      usts;
	logic [SW-1:0]  u_num, u_opd;
	logic [UCW-1:0] u_iters;
	logic [QS-1:0]  u_quo;

	assign strips.ready = (state_q == S_COLLECT);
	assign strip_acc    = strips.valid && strips.ready;
	assign defined      = (strips.event_kind == KIND_IMPLANT)
		|| ((strips.event_kind == KIND_DECAY) && dec_en_q);
	assign cnt_inc      = (cnt_q < CW'(NUM_STRIPS)) ? cnt_q + CW'(1) : cnt_q;
	assign issue        = ((state_q == S_P1) || (state_q == S_P2)) && (rd_idx_q < n_q);
	assign pass_end     = !issue && !v_s1 && !v_s2;

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		load       = 1'b0;
		unit_start = 1'b0;
		enter_p2   = 1'b0;
		case (state_q)
			S_COLLECT: begin
				if (strip_acc && strips.last_strip) begin
					state_d = defined ? S_P1 : S_DONE;
				end
			end
			S_P1: begin
				if (pass_end) begin
					state_d = S_CALC;
					step_d  = ST_CEN;
				end
			end
			S_CALC: begin
				unit_start = 1'b1;
				state_d    = S_WAIT;
			end
			S_WAIT: begin
				if (usts.done) begin
					case (step_q)
						ST_CEN:       begin step_d = ST_CENG; state_d = S_CALC; end
						ST_CENG:      begin
							step_d = ST_SPR_DIV; state_d = S_P2; enter_p2 = 1'b1;
						end
						ST_SPR_DIV:   begin step_d = ST_SPR_SQRT; state_d = S_CALC; end
						ST_SPR_SQRT:  begin
							step_d = ST_SPRG_DIV; state_d = S_P2; enter_p2 = 1'b1;
						end
						ST_SPRG_DIV:  begin step_d = ST_SPRG_SQRT; state_d = S_CALC; end
						ST_SPRG_SQRT: state_d = S_DONE;
						default:      state_d = S_DONE;
					endcase
				end
			end
			S_P2: begin
				if (pass_end) begin
					state_d = S_CALC;
				end
			end
			S_DONE: begin
				if (!res_valid_q || results.ready) begin
					load    = 1'b1;
					state_d = S_COLLECT;
				end
			end
			default: state_d = S_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			step_q      <= ST_CEN;
			sel_g_q     <= 1'b0;
			zero_q      <= 1'b0;
			implant_q   <= 1'b0;
			cnt_q       <= '0;
			n_q         <= '0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (strip_acc) begin
				if (strips.last_strip) begin
					cnt_q     <= '0;
					n_q       <= cnt_inc;
					zero_q    <= !defined;
					implant_q <= (strips.event_kind == KIND_IMPLANT);
					rd_idx_q  <= '0;
				end else begin
					cnt_q <= cnt_inc;
				end
			end
			if (enter_p2) begin
				rd_idx_q <= '0;
				sel_g_q  <= (step_q == ST_SPR_SQRT);
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == S_P2);
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// strip memory
	logic [16:0]   mem [NUM_STRIPS];
	logic [16:0]   rd_data_s1;
	logic [IW-1:0] idx_s1;

	always_ff @(posedge clk) begin
		if (strip_acc && (cnt_q < CW'(NUM_STRIPS))) begin
			mem[cnt_q[IW-1:0]] <= {strips.strip_fired, strips.strip_energy};
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q[IW-1:0]];
			idx_s1     <= rd_idx_q[IW-1:0];
		end
	end

	// gate of this event
	logic [15:0]    gate_lo, gate_hi, e_s1;
	logic           f_s1, ing_s1;
	logic [IW+15:0] ie_s1;

	assign gate_lo = implant_q ? imp_lo_q : dec_lo_q;
	assign gate_hi = implant_q ? imp_hi_q : dec_hi_q;
	assign e_s1    = rd_data_s1[15:0];
	assign f_s1    = rd_data_s1[16];
	assign ing_s1  = (e_s1 > gate_lo) && (e_s1 < gate_hi);
	assign ie_s1   = idx_s1 * e_s1;

	// first pass: sums, counts, top three, peak
	logic [DW-1:0]  d_q, dg_q;
	logic [PW-1:0]  nw_q, nwg_q;
	logic [4:0]     fc_q, gc_q;
	logic [15:0]    top0_q, top1_q, top2_q, peak_e_q;
	logic [IW-1:0]  peak_i_q;
	logic           p1_go;

	assign p1_go = v_s1 && (state_q == S_P1);

	always_ff @(posedge clk) begin
		if (strip_acc && strips.last_strip) begin
			d_q      <= '0;
			dg_q     <= '0;
			nw_q     <= '0;
			nwg_q    <= '0;
			fc_q     <= '0;
			gc_q     <= '0;
			top0_q   <= '0;
			top1_q   <= '0;
			top2_q   <= '0;
			peak_e_q <= '0;
			peak_i_q <= '0;
		end else if (p1_go) begin
			d_q  <= d_q + DW'(e_s1);
			nw_q <= nw_q + PW'(ie_s1);
			if (ing_s1) begin
				dg_q  <= dg_q + DW'(e_s1);
				nwg_q <= nwg_q + PW'(ie_s1);
				if (e_s1 > peak_e_q) begin
					peak_e_q <= e_s1;
					peak_i_q <= idx_s1;
				end
			end
			if (f_s1) begin
				if (fc_q != 5'd31) begin
					fc_q <= fc_q + 5'd1;
				end
				if (ing_s1) begin
					if (gc_q != 5'd31) begin
						gc_q <= gc_q + 5'd1;
					end
					if (e_s1 > top0_q) begin
						top2_q <= top1_q;
						top1_q <= top0_q;
						top0_q <= e_s1;
					end else if (e_s1 > top1_q) begin
						top2_q <= top1_q;
						top1_q <= e_s1;
					end else if (e_s1 > top2_q) begin
						top2_q <= e_s1;
					end
				end
			end
		end
	end

	// second pass: weighted squared distances
	logic [CQ-1:0]         c_q, cg_q, spr_q, sprg_q, cen;
	logic [QS-1:0]         dq_q;
	logic signed [CQ:0]    pos_diff;
	logic signed [2*CQ+1:0] dist_sq;
	logic [QS-1:0]         sqd_s2;
	logic [15:0]           e_s2;
	logic                  take_s2;
	logic [QS+15:0]        prod_s2;
	logic [SW-1:0]         sq_q, sqg_q;

	assign cen      = sel_g_q ? cg_q : c_q;
	assign pos_diff = $signed({1'b0, cen}) - $signed({1'b0, idx_s1, 8'b0});
	assign dist_sq  = pos_diff * pos_diff;
	assign prod_s2  = sqd_s2 * e_s2;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sqd_s2  <= dist_sq[QS-1:0];
			e_s2    <= e_s1;
			take_s2 <= f_s1 && (!sel_g_q || ing_s1);
		end
		if (enter_p2) begin
			if (step_q == ST_CENG) begin
				sq_q <= '0;
			end else begin
				sqg_q <= '0;
			end
		end else if (v_s2 && take_s2) begin
			if (sel_g_q) begin
				sqg_q <= sqg_q + SW'(prod_s2);
			end else begin
				sq_q <= sq_q + SW'(prod_s2);
			end
		end
	end

	// shared unit operands
	always_comb begin
		ucmd.start = unit_start;
		ucmd.op    = OP_DIV;
		u_num      = '0;
		u_opd      = '0;
		u_iters    = UCW'(CQ);
		case (step_q)
			ST_CEN: begin
				u_num = SW'({nw_q, 9'b0}) + SW'(d_q);
				u_opd = SW'(d_q) << CQ;
			end
			ST_CENG: begin
				u_num = SW'({nwg_q, 9'b0}) + SW'(dg_q);
				u_opd = SW'(dg_q) << CQ;
			end
			ST_SPR_DIV: begin
				u_num   = sq_q;
				u_opd   = SW'(d_q) << (QS - 1);
				u_iters = UCW'(QS);
			end
			ST_SPRG_DIV: begin
				u_num   = sqg_q;
				u_opd   = SW'(dg_q) << (QS - 1);
				u_iters = UCW'(QS);
			end
			ST_SPR_SQRT, ST_SPRG_SQRT: begin
				ucmd.op = OP_SQRT;
				u_num   = SW'(dq_q);
				u_opd   = SW'(1) << (QS - 2);
				u_iters = UCW'(QS / 2);
			end
			default: begin
			end
		endcase
	end

	sdcr_unit #(
		.NW   (SW),
		.QW   (QS),
		.CNTW (UCW)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ucmd),
		.num    (u_num),
		.opd    (u_opd),
		.iters  (u_iters),
		.sts    (usts),
		.quo    (u_quo)
	);

	always_ff @(posedge clk) begin
		if ((state_q == S_WAIT) && usts.done) begin
			case (step_q)
				ST_CEN:       c_q    <= u_quo[CQ-1:0];
				ST_CENG:      cg_q   <= u_quo[CQ-1:0];
				ST_SPR_DIV:   dq_q   <= u_quo;
				ST_SPR_SQRT:  spr_q  <= u_quo[CQ-1:0];
				ST_SPRG_DIV:  dq_q   <= u_quo;
				ST_SPRG_SQRT: sprg_q <= u_quo[CQ-1:0];
				default: begin
				end
			endcase
		end
	end

	// result register
	logic d_nz, dg_nz, peak_mode;

	assign d_nz      = (d_q != '0);
	assign dg_nz     = (dg_q != '0);
	assign peak_mode = implant_q && peak_pos_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (zero_q) begin
				results.fired_count          <= '0;
				results.gated_count          <= '0;
				results.top_energy_first     <= '0;
				results.top_energy_second    <= '0;
				results.top_energy_third     <= '0;
				results.energy_sum           <= '0;
				results.centroid             <= '0;
				results.centroid_valid       <= 1'b0;
				results.gated_centroid       <= '0;
				results.gated_centroid_valid <= 1'b0;
				results.spread               <= '0;
				results.gated_spread         <= '0;
			end else begin
				results.fired_count       <= fc_q;
				results.gated_count       <= gc_q;
				results.top_energy_first  <= top0_q;
				results.top_energy_second <= top1_q;
				results.top_energy_third  <= top2_q;
				results.energy_sum        <= sat_sum(32'(d_q));
				results.centroid          <= d_nz ? sat_q12(32'(c_q)) : 12'd0;
				results.centroid_valid    <= d_nz;
				if (peak_mode) begin
					results.gated_centroid <= (peak_e_q != 16'd0)
						? sat_q12(32'({peak_i_q, 8'b0})) : 12'd0;
					results.gated_centroid_valid <= (peak_e_q != 16'd0);
				end else begin
					results.gated_centroid       <= dg_nz ? sat_q12(32'(cg_q)) : 12'd0;
					results.gated_centroid_valid <= dg_nz;
				end
				results.spread       <= d_nz ? sat_q12(32'(spr_q)) : 12'd0;
				results.gated_spread <= dg_nz ? sat_q12(32'(sprg_q)) : 12'd0;
			end
		end
	end

	assign results.valid = res_valid_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NUM_STRIPS)) else $error("strip count beyond strip memory");
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> results.valid) else $error("result load lost");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |-> !load) else $error("pending result overwritten");
	a_unit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_P1 || state_q == S_P2 || state_q == S_COLLECT) |-> !usts.busy)
		else $error("unit busy outside arithmetic steps");
`endif

endmodule
